// File: hw/rtl/bzs_pkg.sv
// shared types and constants for the bezier subdivider
// no dependencies; imported by every module of the block
package bzs_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int NUM_CELLS       = 3;
  localparam int NUM_LEVELS      = NUM_CELLS + 1;
  localparam int NUM_BANKS       = 2;
  localparam int MAX_POINTS      = 7;
  localparam int IDX_BITS        = 3;

  localparam logic [IDX_BITS-1:0] IDX_QUAD_LAST  = IDX_BITS'(4);
  localparam logic [IDX_BITS-1:0] IDX_CUBIC_LAST = IDX_BITS'(6);

  typedef enum logic {
    OP_QUAD  = 1'b0,
    OP_CUBIC = 1'b1
  } bzs_op_t;

  // control that travels with each point through the cell chain
  typedef struct packed {
    logic    valid;
    logic    first;
    logic    last;
    bzs_op_t op;
    logic    bank;
  } bzs_tag_t;

  function automatic logic [IDX_BITS-1:0] last_index(input bzs_op_t op);
    return (op == OP_CUBIC) ? IDX_CUBIC_LAST : IDX_QUAD_LAST;
  endfunction

endpackage

// File: hw/rtl/bzs_cell.sv
// one interpolation cell of the de casteljau chain
// depends on bzs_pkg; blends the previous point with the incoming one
module bzs_cell
  import bzs_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bzs_tag_t                      tag_i,
  input  logic signed [COORD_BITS-1:0]  x_i,
  input  logic signed [COORD_BITS-1:0]  y_i,
  input  logic        [T_FRAC_BITS:0]   t_i,
  output bzs_tag_t                      tag_o,
  output logic signed [COORD_BITS-1:0]  x_o,
  output logic signed [COORD_BITS-1:0]  y_o,
  output logic        [T_FRAC_BITS:0]   t_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + T_FRAC_BITS + 2;
  localparam int SW = PW + 1;

  // a + (b - a) * t, rounded, arithmetic shift back to coordinate scale
  function automatic logic signed [COORD_BITS-1:0] lerp1(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic        [T_FRAC_BITS:0]  t
  );
    logic signed [DW-1:0]            d;
    logic signed [T_FRAC_BITS+1:0]   ts;
    logic signed [PW-1:0]            prod;
    logic signed [SW-1:0]            s;
    logic signed [SW-1:0]            half;
    d    = DW'(b) - DW'(a);
    ts   = signed'({1'b0, t});
    prod = d * ts;
    half = SW'(1);
    half = half <<< (T_FRAC_BITS - 1);
    s    = SW'(a);
    s    = s <<< T_FRAC_BITS;
    s    = s + SW'(prod) + half;
    s    = s >>> T_FRAC_BITS;
    return COORD_BITS'(s);
  endfunction

  logic signed [COORD_BITS-1:0] prev_x_r;
  logic signed [COORD_BITS-1:0] prev_y_r;
  logic                         prev_first_r;
  bzs_tag_t                     tag_r;
  bzs_tag_t                     tag_nxt;
  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;
  logic        [T_FRAC_BITS:0]  t_r;

  // a segment's first word only primes the cell
  always_comb begin
    tag_nxt.valid = tag_i.valid && !tag_i.first;
    tag_nxt.first = prev_first_r;
    tag_nxt.last  = tag_i.last;
    tag_nxt.op    = tag_i.op;
    tag_nxt.bank  = tag_i.bank;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_i.valid) begin
      prev_x_r     <= x_i;
      prev_y_r     <= y_i;
      prev_first_r <= tag_i.first;
    end
    x_r <= lerp1(prev_x_r, x_i, t_i);
    y_r <= lerp1(prev_y_r, y_i, t_i);
    t_r <= t_i;
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign t_o   = t_r;

endmodule

// File: hw/rtl/bzs_feed.sv
// input stage: latches a segment and streams its control points into the chain
// depends on bzs_pkg; one point per cycle, three points for a quadratic segment and four for a cubic
module bzs_feed
  import bzs_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_i,
  input  bzs_op_t                       op_i,
  input  logic                          bank_i,
  input  logic signed [COORD_BITS-1:0]  p0_x_i,
  input  logic signed [COORD_BITS-1:0]  p0_y_i,
  input  logic signed [COORD_BITS-1:0]  p1_x_i,
  input  logic signed [COORD_BITS-1:0]  p1_y_i,
  input  logic signed [COORD_BITS-1:0]  p2_x_i,
  input  logic signed [COORD_BITS-1:0]  p2_y_i,
  input  logic signed [COORD_BITS-1:0]  p3_x_i,
  input  logic signed [COORD_BITS-1:0]  p3_y_i,
  input  logic        [T_FRAC_BITS:0]   split_t_i,
  output logic                          hold_o,
  output bzs_tag_t                      tag_o,
  output logic signed [COORD_BITS-1:0]  x_o,
  output logic signed [COORD_BITS-1:0]  y_o,
  output logic        [T_FRAC_BITS:0]   t_o
);

  localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
  localparam logic [1:0] CNT_QUAD_LAST  = 2'd2;
  localparam logic [1:0] CNT_CUBIC_LAST = 2'd3;

  logic                         active_r;
  logic [1:0]                   cnt_r;
  bzs_op_t                      op_r;
  logic                         bank_r;
  logic signed [COORD_BITS-1:0] px_r [4];
  logic signed [COORD_BITS-1:0] py_r [4];
  logic        [T_FRAC_BITS:0]  t_r;
  logic [1:0]                   cnt_last;
  logic                         feed_last;

  assign cnt_last  = (op_r == OP_CUBIC) ? CNT_CUBIC_LAST : CNT_QUAD_LAST;
  assign feed_last = active_r && (cnt_r == cnt_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (load_i) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (feed_last) begin
        active_r <= 1'b0;
      end
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      op_r    <= op_i;
      bank_r  <= bank_i;
      px_r[0] <= p0_x_i;
      py_r[0] <= p0_y_i;
      px_r[1] <= p1_x_i;
      py_r[1] <= p1_y_i;
      px_r[2] <= p2_x_i;
      py_r[2] <= p2_y_i;
      px_r[3] <= p3_x_i;
      py_r[3] <= p3_y_i;
      // anything above one counts as one
      t_r     <= (split_t_i > T_ONE) ? T_ONE : split_t_i;
    end
  end

  // a new segment may load during the last word of the current one
  assign hold_o = active_r && !feed_last;

  always_comb begin
    tag_o.valid = active_r;
    tag_o.first = (cnt_r == 2'd0);
    tag_o.last  = (cnt_r == cnt_last);
    tag_o.op    = op_r;
    tag_o.bank  = bank_r;
  end

  assign x_o = px_r[cnt_r];
  assign y_o = py_r[cnt_r];
  assign t_o = t_r;

endmodule

// File: hw/rtl/bzs_collect.sv
// result stage: two banks of seven points filled from every level of the chain,
// emitted in index order one per cycle; depends on bzs_pkg
module bzs_collect
  import bzs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bzs_tag_t                      tag_i [NUM_LEVELS],
  input  logic signed [COORD_BITS-1:0]  x_i   [NUM_LEVELS],
  input  logic signed [COORD_BITS-1:0]  y_i   [NUM_LEVELS],
  input  logic                          alloc_i,
  output logic                          wr_bank_o,
  output logic                          bank_free_o,
  output logic                          out_valid_o,
  output logic [IDX_BITS-1:0]           out_idx_o,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic                          out_last_o
);

  logic signed [COORD_BITS-1:0] bx_r [NUM_BANKS][MAX_POINTS];
  logic signed [COORD_BITS-1:0] by_r [NUM_BANKS][MAX_POINTS];
  bzs_op_t                      bop_r [NUM_BANKS];
  logic [NUM_BANKS-1:0]         owned_r;
  logic [NUM_BANKS-1:0]         owned_nxt;
  logic [NUM_BANKS-1:0]         full_r;
  logic [NUM_BANKS-1:0]         full_nxt;
  logic                         wr_bank_r;
  logic                         rd_bank_r;
  logic [IDX_BITS-1:0]          idx_r;
  logic                         out_valid_r;
  logic [IDX_BITS-1:0]          out_idx_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic                         out_last_r;
  logic                         emit;
  logic                         rd_last;
  logic                         rd_done;

  assign emit    = full_r[rd_bank_r];
  assign rd_last = (idx_r == last_index(bop_r[rd_bank_r]));
  assign rd_done = emit && rd_last;

  // level l's first output is point l, its last is point n-1-l
  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (tag_i[l].valid && tag_i[l].first) begin
        bx_r[tag_i[l].bank][IDX_BITS'(l)] <= x_i[l];
        by_r[tag_i[l].bank][IDX_BITS'(l)] <= y_i[l];
      end
      if (tag_i[l].valid && tag_i[l].last) begin
        bx_r[tag_i[l].bank][last_index(tag_i[l].op) - IDX_BITS'(l)] <= x_i[l];
        by_r[tag_i[l].bank][last_index(tag_i[l].op) - IDX_BITS'(l)] <= y_i[l];
      end
      if (tag_i[l].valid && tag_i[l].first && tag_i[l].last) begin
        bop_r[tag_i[l].bank] <= tag_i[l].op;
      end
    end
    out_idx_r  <= idx_r;
    out_x_r    <= bx_r[rd_bank_r][idx_r];
    out_y_r    <= by_r[rd_bank_r][idx_r];
    out_last_r <= rd_last;
  end

  // a bank read out in this cycle can be taken by a new segment at the same edge
  always_comb begin
    owned_nxt = owned_r;
    if (rd_done) begin
      owned_nxt[rd_bank_r] = 1'b0;
    end
    if (alloc_i) begin
      owned_nxt[wr_bank_r] = 1'b1;
    end
  end

  // the middle point is the last one written for a segment
  always_comb begin
    full_nxt = full_r;
    if (rd_done) begin
      full_nxt[rd_bank_r] = 1'b0;
    end
    for (int l = 1; l < NUM_LEVELS; l++) begin
      if (tag_i[l].valid && tag_i[l].first && tag_i[l].last) begin
        full_nxt[tag_i[l].bank] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owned_r     <= '0;
      full_r      <= '0;
      wr_bank_r   <= 1'b0;
      rd_bank_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      owned_r     <= owned_nxt;
      full_r      <= full_nxt;
      if (emit) begin
        if (rd_last) begin
          idx_r     <= '0;
          rd_bank_r <= !rd_bank_r;
        end else begin
          idx_r <= idx_r + IDX_BITS'(1);
        end
      end
      if (alloc_i) begin
        wr_bank_r <= !wr_bank_r;
      end
    end
  end

  assign wr_bank_o   = wr_bank_r;
  assign bank_free_o = !owned_r[wr_bank_r] || (rd_done && (rd_bank_r == wr_bank_r));
  assign out_valid_o = out_valid_r;
  assign out_idx_o   = out_idx_r;
  assign out_x_o     = out_x_r;
  assign out_y_o     = out_y_r;
  assign out_last_o  = out_last_r;

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (out_idx_r == IDX_QUAD_LAST) || (out_idx_r == IDX_CUBIC_LAST))
    else $error("last flag on a point that cannot end a segment");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=>
      out_valid_r && (out_idx_r == IDX_BITS'($past(out_idx_r) + IDX_BITS'(1))))
    else $error("gap or skip inside a segment's points");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r || (out_idx_r == '0))
    else $error("new segment does not start at point zero");

  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_i |-> !owned_r[wr_bank_r] || (rd_done && (rd_bank_r == wr_bank_r)))
    else $error("segment taken into a bank still in use");

  a_full_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r & ~owned_r) == '0)
    else $error("bank complete without an owner");

endmodule

// File: hw/rtl/bezier_subdivide.sv
// bezier_subdivide: de casteljau split of a quadratic or cubic segment at t
// the rate is set by the single result port, which sends each point of a segment in turn;
//   the point chain itself takes segments faster than that and can take a new one while the
//   last is still in it, and the two result banks let one segment fill while another is read out
// reset: synchronous active-low rst_n empties the chain and both result banks
// results go out one per cycle with no back-pressure from the receiver
module bezier_subdivide
  import bzs_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_p0_x,
  input  logic signed [COORD_BITS-1:0]  in_p0_y,
  input  logic signed [COORD_BITS-1:0]  in_p1_x,
  input  logic signed [COORD_BITS-1:0]  in_p1_y,
  input  logic signed [COORD_BITS-1:0]  in_p2_x,
  input  logic signed [COORD_BITS-1:0]  in_p2_y,
  input  logic signed [COORD_BITS-1:0]  in_p3_x,
  input  logic signed [COORD_BITS-1:0]  in_p3_y,
  input  logic        [T_FRAC_BITS:0]   in_split_t,
  output logic                          out_valid,
  output logic [IDX_BITS-1:0]           out_point_index,
  output logic signed [COORD_BITS-1:0]  out_x,
  output logic signed [COORD_BITS-1:0]  out_y,
  output logic                          out_last
);

  bzs_tag_t                     lvl_tag [NUM_LEVELS];
  logic signed [COORD_BITS-1:0] lvl_x   [NUM_LEVELS];
  logic signed [COORD_BITS-1:0] lvl_y   [NUM_LEVELS];
  logic        [T_FRAC_BITS:0]  lvl_t   [NUM_CELLS];
  logic                         feed_hold;
  logic                         wr_bank;
  logic                         bank_free;
  logic                         accept;

  assign busy   = feed_hold || !bank_free;
  assign accept = start && !busy;

  bzs_feed #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_feed (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (accept),
    .op_i      (bzs_op_t'(in_op)),
    .bank_i    (wr_bank),
    .p0_x_i    (in_p0_x),
    .p0_y_i    (in_p0_y),
    .p1_x_i    (in_p1_x),
    .p1_y_i    (in_p1_y),
    .p2_x_i    (in_p2_x),
    .p2_y_i    (in_p2_y),
    .p3_x_i    (in_p3_x),
    .p3_y_i    (in_p3_y),
    .split_t_i (in_split_t),
    .hold_o    (feed_hold),
    .tag_o     (lvl_tag[0]),
    .x_o       (lvl_x[0]),
    .y_o       (lvl_y[0]),
    .t_o       (lvl_t[0])
  );

  // each cell turns n points of a level into n-1 points of the next
  for (genvar c = 1; c <= NUM_CELLS; c++) begin : g_cell
    if (c < NUM_CELLS) begin : g_mid
      bzs_cell #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .tag_i (lvl_tag[c-1]),
        .x_i   (lvl_x[c-1]),
        .y_i   (lvl_y[c-1]),
        .t_i   (lvl_t[c-1]),
        .tag_o (lvl_tag[c]),
        .x_o   (lvl_x[c]),
        .y_o   (lvl_y[c]),
        .t_o   (lvl_t[c])
      );
    end else begin : g_end
      bzs_cell #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .tag_i (lvl_tag[c-1]),
        .x_i   (lvl_x[c-1]),
        .y_i   (lvl_y[c-1]),
        .t_i   (lvl_t[c-1]),
        .tag_o (lvl_tag[c]),
        .x_o   (lvl_x[c]),
        .y_o   (lvl_y[c]),
        .t_o   ()
      );
    end
  end

  bzs_collect #(
    .COORD_BITS (COORD_BITS)
  ) u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag_i       (lvl_tag),
    .x_i         (lvl_x),
    .y_i         (lvl_y),
    .alloc_i     (accept),
    .wr_bank_o   (wr_bank),
    .bank_free_o (bank_free),
    .out_valid_o (out_valid),
    .out_idx_o   (out_point_index),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_last_o  (out_last)
  );

endmodule

// File: test/tb_top.sv
// testbench for bezier_subdivide: directed table, then random segments in three idle phases
// depends on bzs_pkg and bezier_subdivide; each split is predicted and checked point by point
module tb_top;
  import bzs_pkg::*;

  localparam int CW       = COORD_BITS_DEF;
  localparam int TW       = T_FRAC_BITS_DEF + 1;
  localparam int T_ONE    = 1 << T_FRAC_BITS_DEF;
  localparam int T_HALF   = T_ONE / 2;
  localparam int CMAX     = (1 << (CW - 1)) - 1;
  localparam int CMIN     = -(1 << (CW - 1));
  localparam int RAND_PER_PHASE = 120;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct packed {
    bzs_op_t         op;
    logic [CW-1:0]   p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    logic [TW-1:0]   t;
  } seg_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [CW-1:0]       x;
    logic [CW-1:0]       y;
    logic                last;
  } point_t;

  // typed rows carry the split point as read off the inputs
  typedef struct packed {
    bzs_op_t op;
    int      p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    int      t;
    bit      typed;
    int      mid_x, mid_y;
  } dir_row_t;

  localparam int NUM_DIR = 16;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{OP_QUAD,  1000, -2000, 3000, 4000, -5000, 6000, 0, 0, 0, 1'b1, 1000, -2000},
    '{OP_QUAD,  1000, -2000, 3000, 4000, -5000, 6000, 0, 0, T_ONE, 1'b1, -5000, 6000},
    '{OP_CUBIC, 256, 512, -768, 1024, 1280, -1536, 1792, 2048, 0, 1'b1, 256, 512},
    '{OP_CUBIC, 256, 512, -768, 1024, 1280, -1536, 1792, 2048, T_ONE, 1'b1, 1792, 2048},
    // t above one saturates
    '{OP_QUAD,  77, 88, 99, -11, -22, 33, 0, 0, T_ONE + 1, 1'b1, -22, 33},
    '{OP_CUBIC, 5, 6, 7, 8, 9, 10, -11, -12, 2 * T_ONE - 1, 1'b1, -11, -12},
    '{OP_CUBIC, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, T_HALF, 1'b1, CMAX, CMAX},
    '{OP_CUBIC, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 12345, 1'b1, CMIN, CMIN},
    // quadratic ignores p3
    '{OP_QUAD,  CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, 40000, 1'b1, CMIN, CMIN},
    '{OP_QUAD,  0, 0, 0, 0, 0, 0, CMAX, CMIN, T_HALF, 1'b1, 0, 0},
    '{OP_QUAD,  CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, T_HALF, 1'b0, 0, 0},
    '{OP_CUBIC, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, T_HALF, 1'b0, 0, 0},
    '{OP_CUBIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 1, 1'b0, 0, 0},
    '{OP_CUBIC, -1, -1, 1, 1, -1, 1, 1, -1, T_ONE - 1, 1'b0, 0, 0},
    '{OP_QUAD,  -3, 5, 7, -9, 11, -13, 0, 0, 3, 1'b0, 0, 0},
    '{OP_CUBIC, 100, -100, -300, 300, 500, -500, -700, 700, 21845, 1'b0, 0, 0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_op;
  logic signed [CW-1:0] in_p0_x, in_p0_y, in_p1_x, in_p1_y;
  logic signed [CW-1:0] in_p2_x, in_p2_y, in_p3_x, in_p3_y;
  logic [TW-1:0]        in_split_t;
  logic                 out_valid;
  logic [IDX_BITS-1:0]  out_point_index;
  logic signed [CW-1:0] out_x, out_y;
  logic                 out_last;

  point_t pending_points[$];
  int     errors = 0;
  int     points_checked = 0;
  int     quad_count = 0;
  int     cubic_count = 0;
  int     idle_pct = 0;
  int     cycle_count = 0;

  bezier_subdivide u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_p0_x        (in_p0_x),
    .in_p0_y        (in_p0_y),
    .in_p1_x        (in_p1_x),
    .in_p1_y        (in_p1_y),
    .in_p2_x        (in_p2_x),
    .in_p2_y        (in_p2_y),
    .in_p3_x        (in_p3_x),
    .in_p3_y        (in_p3_y),
    .in_split_t     (in_split_t),
    .out_valid      (out_valid),
    .out_point_index(out_point_index),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor((a*(one-t) + b*t + half) / one)
  function automatic longint lerp_coord(longint a, longint b, longint t);
    return (a * (T_ONE - t) + b * t + T_HALF) >>> T_FRAC_BITS_DEF;
  endfunction

  function automatic void predict_split(seg_t s, bit typed, int mid_x, int mid_y);
    longint px[4];
    longint py[4];
    longint qx[7];
    longint qy[7];
    longint mx, my, t;
    int     n;
    int     mid;
    point_t pt;
    px[0] = longint'($signed(s.p0x)); py[0] = longint'($signed(s.p0y));
    px[1] = longint'($signed(s.p1x)); py[1] = longint'($signed(s.p1y));
    px[2] = longint'($signed(s.p2x)); py[2] = longint'($signed(s.p2y));
    px[3] = longint'($signed(s.p3x)); py[3] = longint'($signed(s.p3y));
    t = (s.t > T_ONE) ? T_ONE : longint'(s.t);
    qx[0] = px[0];
    qy[0] = py[0];
    qx[1] = lerp_coord(px[0], px[1], t);
    qy[1] = lerp_coord(py[0], py[1], t);
    if (s.op == OP_QUAD) begin
      qx[4] = px[2];
      qy[4] = py[2];
      qx[3] = lerp_coord(px[1], px[2], t);
      qy[3] = lerp_coord(py[1], py[2], t);
      qx[2] = lerp_coord(qx[1], qx[3], t);
      qy[2] = lerp_coord(qy[1], qy[3], t);
      n = 5;
    end else begin
      mx = lerp_coord(px[1], px[2], t);
      my = lerp_coord(py[1], py[2], t);
      qx[6] = px[3];
      qy[6] = py[3];
      qx[5] = lerp_coord(px[2], px[3], t);
      qy[5] = lerp_coord(py[2], py[3], t);
      qx[2] = lerp_coord(qx[1], mx, t);
      qy[2] = lerp_coord(qy[1], my, t);
      qx[4] = lerp_coord(mx, qx[5], t);
      qy[4] = lerp_coord(my, qy[5], t);
      qx[3] = lerp_coord(qx[2], qx[4], t);
      qy[3] = lerp_coord(qy[2], qy[4], t);
      n = 7;
    end
    mid = (n - 1) / 2;
    if (typed) begin
      qx[mid] = longint'(mid_x);
      qy[mid] = longint'(mid_y);
    end
    for (int i = 0; i < n; i++) begin
      pt.idx  = IDX_BITS'(i);
      pt.x    = CW'(qx[i]);
      pt.y    = CW'(qy[i]);
      pt.last = (i == n - 1);
      pending_points.push_back(pt);
    end
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CW'(CMAX);
      1: return CW'(CMIN);
      2: return CW'(int'($urandom_range(2047)) - 1024);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_split();
    case ($urandom_range(15))
      0: return TW'(0);
      1: return TW'(T_ONE);
      2: return TW'(T_ONE + int'($urandom_range(T_ONE - 1, 1)));
      3: return TW'($urandom_range(3));
      default: return TW'($urandom_range(T_ONE));
    endcase
  endfunction

  function automatic seg_t random_segment();
    seg_t s;
    s.op  = bzs_op_t'($urandom_range(1));
    s.p0x = rand_coord(); s.p0y = rand_coord();
    s.p1x = rand_coord(); s.p1y = rand_coord();
    s.p2x = rand_coord(); s.p2y = rand_coord();
    s.p3x = rand_coord(); s.p3y = rand_coord();
    s.t   = rand_split();
    return s;
  endfunction

  // present a word, hold it until taken, then maybe idle for a random gap set by idle_pct
  task automatic issue(input seg_t s, input bit typed, input int mid_x, input int mid_y);
    int gap;
    in_op      <= s.op;
    in_p0_x    <= s.p0x;
    in_p0_y    <= s.p0y;
    in_p1_x    <= s.p1x;
    in_p1_y    <= s.p1y;
    in_p2_x    <= s.p2x;
    in_p2_y    <= s.p2y;
    in_p3_x    <= s.p3x;
    in_p3_y    <= s.p3y;
    in_split_t <= s.t;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    predict_split(s, typed, mid_x, mid_y);
    if (s.op == OP_QUAD) quad_count++;
    else cubic_count++;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point idx %0d x %0d y %0d last %0b", $time,
                 out_point_index, out_x, out_y, out_last);
        errors++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (out_point_index !== want.idx) note_mismatch("point_index", want.idx, out_point_index);
        if (out_x !== want.x) note_mismatch("x", $signed(want.x), out_x);
        if (out_y !== want.y) note_mismatch("y", $signed(want.y), out_y);
        if (out_last !== want.last) note_mismatch("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("bezier_subdivide test failed");
      $finish;
    end
  end

  initial begin
    seg_t s;
    int   phase_pct [3] = '{22, 74, 0};
    rst_n      = 1'b0;
    start      = 1'b0;
    in_op      = 1'b0;
    in_p0_x    = '0;
    in_p0_y    = '0;
    in_p1_x    = '0;
    in_p1_y    = '0;
    in_p2_x    = '0;
    in_p2_y    = '0;
    in_p3_x    = '0;
    in_p3_y    = '0;
    in_split_t = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = phase_pct[0];
    for (int i = 0; i < NUM_DIR; i++) begin
      s.op  = dir_rows[i].op;
      s.p0x = CW'(dir_rows[i].p0x); s.p0y = CW'(dir_rows[i].p0y);
      s.p1x = CW'(dir_rows[i].p1x); s.p1y = CW'(dir_rows[i].p1y);
      s.p2x = CW'(dir_rows[i].p2x); s.p2y = CW'(dir_rows[i].p2y);
      s.p3x = CW'(dir_rows[i].p3x); s.p3y = CW'(dir_rows[i].p3y);
      s.t   = TW'(dir_rows[i].t);
      issue(s, dir_rows[i].typed, dir_rows[i].mid_x, dir_rows[i].mid_y);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      repeat (RAND_PER_PHASE) issue(random_segment(), 1'b0, 0, 0);
    end
    start <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    // catch any stray points after the last expected one
    repeat (16) @(posedge clk);

    $display("split %0d quadratic and %0d cubic segments, %0d points checked, %0d errors",
             quad_count, cubic_count, points_checked, errors);
    if (errors == 0) begin
      $display("bezier_subdivide test passed");
    end else begin
      $display("bezier_subdivide test failed");
    end
    $finish;
  end

endmodule
